FILE: rtl/core/obdd_pkg.sv
// ----------------------------------------------------------------------------
// obdd_pkg
// shared types and constants of the order book density detector
// ----------------------------------------------------------------------------
package obdd_pkg;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 160;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    // distance and significance result fields are saturated at this width
    localparam int            SAT_W   = 16;
    localparam logic [15:0]   SAT_MAX = 16'hFFFF;

    // distance in basis points: |price - mid| * 10000 / mid
    localparam int DIST_SCALE = 10000;
    localparam int DIST_NUM_W = 46;

    localparam logic [5:0]  SCAN_DEPTH_RST = 6'd20;
    localparam logic [15:0] THRESHOLD_RST  = 16'd768;
    localparam logic [63:0] MIN_QUOTE_RST  = 64'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_DEPTH = 2'd0,
        CFG_THRESHOLD  = 2'd1,
        CFG_MIN_QUOTE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic clr_store;
        logic clr_book;
        logic side_first;
        logic side_next;
        logic idx_inc;
        logic rd;
        logic mul;
        logic cmp;
        logic div_start;
        logic div_sel;
        logic lat_dist;
        logic lat_sig;
        logic insert;
        logic out_inc;
        logic out_clr;
    } t_cmd;

    typedef struct packed {
        logic book_ok;
        logic side_ok;
        logic side_ask;
        logic idx_end;
        logic div_done;
        logic pass;
        logic out_last;
    } t_sts;

endpackage

FILE: rtl/core/order_book_density_detector_core.sv
// ----------------------------------------------------------------------------
// order_book_density_detector_core
// finds large resting levels in an order book snapshot and reports them sorted
// ----------------------------------------------------------------------------
// A snapshot arrives as price levels, one transfer per cycle, bids and asks in
// book order, tlast on the final level. After it the block scans the kept levels
// of each side through the states RD, MUL, CMP and DST; each level that passes
// the density test also runs the shared 16-step divider for distance and then
// significance. Results then leave one transfer per cycle while the receiver is
// ready, highest significance first, or one empty result when nothing is found.
// Input is not accepted between the final level and the final result transfer.
// ----------------------------------------------------------------------------
module order_book_density_detector_core #(
    parameter int MAX_DEPTH     = 32,
    parameter int MAX_DENSITIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // mid_price, price, quantity
    input  logic [0:0]   i_s_tuser,   // side
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [159:0] o_m_tdata,   // out_price, out_quantity, quote_volume,
                                      // distance_bp, significance
    output logic [1:0]   o_m_tuser,   // found, out_side
    output logic         o_m_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);
    import obdd_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_found;
    logic        w_side;
    logic [31:0] w_price;
    logic [31:0] w_qty;
    logic [63:0] w_quote;
    logic [15:0] w_dist;
    logic [15:0] w_sig;

    obdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    obdd_dp #(
        .MAX_DEPTH     (MAX_DEPTH),
        .MAX_DENSITIES (MAX_DENSITIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mid      (i_s_tdata[31:0]),
        .i_side     (i_s_tuser[0]),
        .i_price    (i_s_tdata[63:32]),
        .i_qty      (i_s_tdata[95:64]),
        .o_found    (w_found),
        .o_side     (w_side),
        .o_price    (w_price),
        .o_qty      (w_qty),
        .o_quote    (w_quote),
        .o_dist     (w_dist),
        .o_sig      (w_sig),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {w_sig, w_dist, w_quote, w_qty, w_price};
    assign o_m_tuser = {w_side, w_found};

endmodule

FILE: rtl/core/obdd_div.sv
// ----------------------------------------------------------------------------
// obdd_div
// restoring divider, one quotient bit per cycle, quotient saturated to 16 bits
// ----------------------------------------------------------------------------
module obdd_div #(
    parameter int DVD_W = 46,
    parameter int DVS_W = 37
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_done,
    output logic [15:0]      o_quot
);
    import obdd_pkg::*;

    localparam int W   = (DVD_W > DVS_W + SAT_W) ? DVD_W : DVS_W + SAT_W;
    localparam int CNW = $clog2(SAT_W);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_sh;
    logic [15:0]    r_q;
    logic           w_sat;
    logic           w_ge;

    // quotient does not fit in 16 bits
    assign w_sat = W'(i_dvd) >= (W'(i_dvs) << SAT_W);
    assign w_ge  = r_rem >= r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
                r_cnt  <= CNW'(SAT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= W'(i_dvd);
            r_sh  <= W'(i_dvs) << (SAT_W - 1);
            r_q   <= w_sat ? SAT_MAX : 16'd0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_sh;
            end
            r_q  <= {r_q[14:0], w_ge};
            r_sh <= r_sh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/core/obdd_dp.sv
// ----------------------------------------------------------------------------
// obdd_dp
// level memories, side sums, density test, divider and sorted result store
// ----------------------------------------------------------------------------
module obdd_dp #(
    parameter int MAX_DEPTH     = 32,
    parameter int MAX_DENSITIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  obdd_pkg::t_cmd                i_cmd,
    output obdd_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [obdd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [obdd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]                   i_mid,
    input  logic                          i_side,
    input  logic [31:0]                   i_price,
    input  logic [31:0]                   i_qty,
    output logic                          o_found,
    output logic                          o_side,
    output logic [31:0]                   o_price,
    output logic [31:0]                   o_qty,
    output logic [63:0]                   o_quote,
    output logic [15:0]                   o_dist,
    output logic [15:0]                   o_sig,
    output logic                          o_last
);
    import obdd_pkg::*;

    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW    = $clog2(MAX_DEPTH + 1);
    localparam int SW    = 32 + AW;
    localparam int SCL_W = 32 + CW + 8;
    localparam int THR_W = SW + 16;
    localparam int CMP_W = (SCL_W > THR_W) ? SCL_W : THR_W;
    localparam int DVD_W = (SCL_W > DIST_NUM_W) ? SCL_W : DIST_NUM_W;
    localparam int OW    = (MAX_DENSITIES > 1) ? $clog2(MAX_DENSITIES) : 1;
    localparam int SCW   = $clog2(MAX_DENSITIES + 1);
    localparam int ENT_W = 1 + 32 + 32 + 64 + 16 + 16;

    logic [5:0]  r_scan_depth;
    logic [15:0] r_thr;
    logic [63:0] r_minq;

    logic [63:0]   r_bid_mem [MAX_DEPTH];
    logic [63:0]   r_ask_mem [MAX_DEPTH];
    logic [CW-1:0] r_bid_cnt;
    logic [CW-1:0] r_ask_cnt;
    logic [SW-1:0] r_bid_sum;
    logic [SW-1:0] r_ask_sum;
    logic [31:0]   r_mid;

    logic          r_side;
    logic [AW-1:0] r_idx;
    logic [63:0]   r_rd;

    logic [SCL_W-1:0]      r_scaled;
    logic [THR_W-1:0]      r_thp;
    logic [63:0]           r_quote;
    logic [31:0]           r_diff;
    logic                  r_pass;
    logic [DIST_NUM_W-1:0] r_dnum;
    logic [15:0]           r_dist;
    logic [15:0]           r_sig;

    logic [ENT_W-1:0] r_st [MAX_DENSITIES];
    logic [SCW-1:0]   r_st_cnt;
    logic [OW-1:0]    r_oidx;

    logic                 w_bid_room;
    logic                 w_ask_room;
    logic [CW-1:0]        w_cur_cnt;
    logic [SW-1:0]        w_cur_sum;
    logic [32+CW-1:0]     w_qc;
    logic [DVD_W-1:0]     w_dvd;
    logic [SW-1:0]        w_dvs;
    logic                 w_div_done;
    logic [15:0]          w_quot;
    logic                 w_room;
    logic [MAX_DENSITIES-1:0] w_keep;
    logic [ENT_W-1:0]     w_new;
    logic [ENT_W-1:0]     w_ent;

    assign w_bid_room = (32'(r_bid_cnt) < 32'(r_scan_depth)) && (32'(r_bid_cnt) < MAX_DEPTH);
    assign w_ask_room = (32'(r_ask_cnt) < 32'(r_scan_depth)) && (32'(r_ask_cnt) < MAX_DEPTH);
    assign w_cur_cnt  = r_side ? r_ask_cnt : r_bid_cnt;
    assign w_cur_sum  = r_side ? r_ask_sum : r_bid_sum;
    assign w_qc       = (32+CW)'(r_rd[63:32]) * (32+CW)'(w_cur_cnt);
    assign w_dvd      = i_cmd.div_sel ? DVD_W'(r_scaled) : DVD_W'(r_dnum);
    assign w_dvs      = i_cmd.div_sel ? w_cur_sum : SW'(r_mid);
    assign w_room     = r_st_cnt < SCW'(MAX_DENSITIES);
    assign w_new      = {r_side, r_rd[31:0], r_rd[63:32], r_quote, r_dist, r_sig};

    // level memories, price in the low half and quantity in the high half
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!i_side && w_bid_room) begin
                r_bid_mem[r_bid_cnt[AW-1:0]] <= {i_qty, i_price};
            end
            if (i_side && w_ask_room) begin
                r_ask_mem[r_ask_cnt[AW-1:0]] <= {i_qty, i_price};
            end
        end
        if (i_cmd.rd) begin
            r_rd <= r_side ? r_ask_mem[r_idx] : r_bid_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_depth <= SCAN_DEPTH_RST;
            r_thr        <= THRESHOLD_RST;
            r_minq       <= MIN_QUOTE_RST;
            r_bid_cnt    <= '0;
            r_ask_cnt    <= '0;
            r_bid_sum    <= '0;
            r_ask_sum    <= '0;
            r_side       <= 1'b0;
            r_idx        <= '0;
            r_st_cnt     <= '0;
            r_oidx       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SCAN_DEPTH: r_scan_depth <= i_cfg_data[5:0];
                    CFG_THRESHOLD:  r_thr        <= i_cfg_data[15:0];
                    CFG_MIN_QUOTE:  r_minq       <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (!i_side && w_bid_room) begin
                    r_bid_cnt <= r_bid_cnt + CW'(1);
                    r_bid_sum <= r_bid_sum + SW'(i_qty);
                end
                if (i_side && w_ask_room) begin
                    r_ask_cnt <= r_ask_cnt + CW'(1);
                    r_ask_sum <= r_ask_sum + SW'(i_qty);
                end
            end
            if (i_cmd.clr_book) begin
                r_bid_cnt <= '0;
                r_ask_cnt <= '0;
                r_bid_sum <= '0;
                r_ask_sum <= '0;
            end
            if (i_cmd.side_first) begin
                r_side <= 1'b0;
                r_idx  <= '0;
            end
            if (i_cmd.side_next) begin
                r_side <= 1'b1;
                r_idx  <= '0;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.clr_store) begin
                r_st_cnt <= '0;
            end
            if (i_cmd.insert && w_room) begin
                r_st_cnt <= r_st_cnt + SCW'(1);
            end
            if (i_cmd.out_inc) begin
                r_oidx <= r_oidx + OW'(1);
            end
            if (i_cmd.out_clr) begin
                r_oidx <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mid <= i_mid;
        end
        if (i_cmd.mul) begin
            r_scaled <= {w_qc, 8'd0};
            r_thp    <= THR_W'(w_cur_sum) * THR_W'(r_thr);
            r_quote  <= 64'(r_rd[31:0]) * 64'(r_rd[63:32]);
            r_diff   <= (r_rd[31:0] >= r_mid) ? r_rd[31:0] - r_mid : r_mid - r_rd[31:0];
        end
        if (i_cmd.cmp) begin
            r_pass <= (CMP_W'(r_scaled) >= CMP_W'(r_thp)) && (r_quote >= r_minq);
            r_dnum <= DIST_NUM_W'(r_diff) * DIST_NUM_W'(DIST_SCALE);
        end
        if (i_cmd.lat_dist) begin
            r_dist <= w_quot;
        end
        if (i_cmd.lat_sig) begin
            r_sig <= w_quot;
        end
    end

    obdd_div #(
        .DVD_W (DVD_W),
        .DVS_W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // sorted insert: entries at or above the new significance stay, the rest move down
    for (genvar g = 0; g < MAX_DENSITIES; g++) begin : g_store
        assign w_keep[g] = (SCW'(g) < r_st_cnt) && (r_st[g][15:0] >= r_sig);
        always_ff @(posedge i_clk) begin
            if (i_cmd.insert && w_room && !w_keep[g]) begin
                if (g == 0) begin
                    r_st[g] <= w_new;
                end else begin
                    r_st[g] <= w_keep[(g > 0) ? g - 1 : 0] ? w_new : r_st[(g > 0) ? g - 1 : 0];
                end
            end
        end
    end

    assign w_ent   = r_st[r_oidx];
    assign o_found = r_st_cnt != '0;
    assign o_side  = o_found ? w_ent[ENT_W-1] : 1'b0;
    assign o_price = o_found ? w_ent[159:128] : 32'd0;
    assign o_qty   = o_found ? w_ent[127:96] : 32'd0;
    assign o_quote = o_found ? w_ent[95:32] : 64'd0;
    assign o_dist  = o_found ? w_ent[31:16] : 16'd0;
    assign o_sig   = o_found ? w_ent[15:0] : 16'd0;
    assign o_last  = !o_found || ((SCW'(r_oidx) + SCW'(1)) == r_st_cnt);

    assign o_sts.book_ok  = (r_mid != 32'd0) && (r_bid_cnt != '0) && (r_ask_cnt != '0);
    assign o_sts.side_ok  = (w_cur_cnt != '0) && (w_cur_sum != '0);
    assign o_sts.side_ask = r_side;
    assign o_sts.idx_end  = (CW'(r_idx) + CW'(1)) == w_cur_cnt;
    assign o_sts.div_done = w_div_done;
    assign o_sts.pass     = r_pass;
    assign o_sts.out_last = o_last;

endmodule

FILE: rtl/core/obdd_ctrl.sv
// ----------------------------------------------------------------------------
// obdd_ctrl
// sequencer for load, end-of-book scan, division and result transfer
// ----------------------------------------------------------------------------
module obdd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tlast,
    input  logic           i_m_tready,
    input  obdd_pkg::t_sts i_sts,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    output obdd_pkg::t_cmd o_cmd
);
    import obdd_pkg::*;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_START = 11'b00000000010,
        S_SIDE  = 11'b00000000100,
        S_RD    = 11'b00000001000,
        S_MUL   = 11'b00000010000,
        S_CMP   = 11'b00000100000,
        S_DST   = 11'b00001000000,
        S_DW    = 11'b00010000000,
        S_SST   = 11'b00100000000,
        S_SW    = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ins_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_s_tlast) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.clr_store  = 1'b1;
                o_cmd.side_first = 1'b1;
                if (i_sts.book_ok) begin
                    n_state = S_SIDE;
                end else begin
                    o_cmd.clr_book = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_SIDE: begin
                if (i_sts.side_ok) begin
                    n_state = S_RD;
                end else if (i_sts.side_ask) begin
                    o_cmd.clr_book = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.side_next = 1'b1;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_DST;
            end
            S_DST: begin
                o_cmd.insert = r_ins_pend;
                if (i_sts.pass && !r_ins_pend) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DW;
                end else if (!i_sts.idx_end) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end else if (i_sts.side_ask) begin
                    o_cmd.clr_book = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.side_next = 1'b1;
                    n_state         = S_SIDE;
                end
            end
            S_DW: begin
                if (i_sts.div_done) begin
                    o_cmd.lat_dist = 1'b1;
                    n_state        = S_SST;
                end
            end
            S_SST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state         = S_SW;
            end
            S_SW: begin
                o_cmd.div_sel = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.lat_sig = 1'b1;
                    // the store takes the level in the next cycle, in S_DST, then the next level
                    n_state       = S_DST;
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    if (i_sts.out_last) begin
                        o_cmd.out_clr = 1'b1;
                        n_state       = S_LOAD;
                    end else begin
                        o_cmd.out_inc = 1'b1;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign o_s_tready = r_state == S_LOAD;
    assign o_m_tvalid = r_state == S_OUT;

    // insert after the significance is latched, with pass already consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_pend <= 1'b0;
        end else begin
            r_ins_pend <= (r_state == S_SW) && i_sts.div_done;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input and output handshakes open together");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DW || r_state == S_SW))
        else $error("divider finished outside a wait state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && i_sts.out_last) |=> o_s_tready)
        else $error("no return to load after the final result transfer");

endmodule

FILE: test/order_book_density_detector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// order_book_density_detector_core_tb
// self-checking bench for the order book density detector
// ----------------------------------------------------------------------------
// Snapshots are streamed in as price levels. A behavioral predictor keeps its
// own copy of the book and the registers, and queues the densities that each
// final level should produce. A monitor compares every result transfer with
// the oldest queued entry, field by field. Directed books cover the field
// extremes and the corner cases: no data, empty side, zero average, depth
// limits and a full store. Random books then run under several register
// settings and idling mixes.
// ----------------------------------------------------------------------------
module order_book_density_detector_core_tb;
    import obdd_pkg::*;

    localparam int DEPTH_CAP = 32;
    localparam int STORE_CAP = 16;
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic        found;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        logic [63:0] quote;
        logic [15:0] dist_bp;
        logic [15:0] sig;
        logic        last;
    } density_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [95:0]  s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_idx = '0;
    logic [63:0]  cfg_data = '0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [159:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;

    order_book_density_detector_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [5:0]  depth_reg = SCAN_DEPTH_RST;
    logic [15:0] mult_reg  = THRESHOLD_RST;
    logic [63:0] minq_reg  = MIN_QUOTE_RST;
    logic [31:0] book_price [2][DEPTH_CAP];
    logic [31:0] book_qty   [2][DEPTH_CAP];
    int unsigned book_n     [2] = '{0, 0};
    logic [63:0] book_sum   [2] = '{0, 0};

    density_t expected_densities [$];
    int  fails = 0;
    int  levels_sent = 0;
    int  snd_idle = 0;
    int  rcv_stall = 0;
    int  quiet_cycles = 0;

    // receiver stalls
    always @(negedge i_clk) m_tready <= ($urandom_range(99) >= rcv_stall);

    task automatic report(string name, logic [63:0] want, logic [63:0] got);
        $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
        fails++;
    endtask

    always @(posedge i_clk) begin
        density_t got, want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = '{found: o_m_tuser[0], side: o_m_tuser[1], price: o_m_tdata[31:0],
                    qty: o_m_tdata[63:32], quote: o_m_tdata[127:64],
                    dist_bp: o_m_tdata[143:128], sig: o_m_tdata[159:144],
                    last: o_m_tlast};
            if (expected_densities.size() == 0) begin
                $display("%0t unexpected result transfer %p", $time, got);
                fails++;
            end else begin
                want = expected_densities.pop_front();
                if (got.found !== want.found) report("found", want.found, got.found);
                if (got.side !== want.side) report("out_side", want.side, got.side);
                if (got.price !== want.price) report("out_price", want.price, got.price);
                if (got.qty !== want.qty) report("out_quantity", want.qty, got.qty);
                if (got.quote !== want.quote) report("quote_volume", want.quote, got.quote);
                if (got.dist_bp !== want.dist_bp)
                    report("distance_bp", want.dist_bp, got.dist_bp);
                if (got.sig !== want.sig) report("significance", want.sig, got.sig);
                if (got.last !== want.last) report("result_last", want.last, got.last);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL order_book_density_detector_core");
            $finish;
        end
    end

    task automatic predict_level(logic [31:0] mid, logic side, logic [31:0] price,
                                 logic [31:0] qty, logic last);
        int unsigned depth;
        density_t dens [STORE_CAP];
        density_t key;
        int nd;
        int j;
        logic [63:0] scaled, diff, dist_full, sig, quote;
        depth = (depth_reg > DEPTH_CAP) ? DEPTH_CAP : depth_reg;
        nd = 0;
        if (book_n[side] < depth) begin
            book_price[side][book_n[side]] = price;
            book_qty[side][book_n[side]] = qty;
            book_sum[side] += qty;
            book_n[side]++;
        end
        if (!last) return;
        if (mid != 0 && book_n[0] != 0 && book_n[1] != 0) begin
            for (int s = 0; s < 2; s++) begin
                if (book_sum[s] == 0) continue;
                for (int i = 0; i < book_n[s]; i++) begin
                    scaled = 64'(book_qty[s][i]) * book_n[s] * 256;
                    if (scaled < book_sum[s] * mult_reg) continue;
                    quote = 64'(book_price[s][i]) * book_qty[s][i];
                    if (quote < minq_reg) continue;
                    diff = (book_price[s][i] >= mid) ? 64'(book_price[s][i] - mid)
                                                     : 64'(mid - book_price[s][i]);
                    dist_full = diff * 10000 / mid;
                    sig = scaled / book_sum[s];
                    if (nd < STORE_CAP) begin
                        dens[nd] = '{found: 1'b1, side: s[0], price: book_price[s][i],
                                     qty: book_qty[s][i], quote: quote,
                                     dist_bp: (dist_full > 65535) ? SAT_MAX
                                                                  : dist_full[15:0],
                                     sig: (sig > 65535) ? SAT_MAX : sig[15:0],
                                     last: 1'b0};
                        nd++;
                    end
                end
            end
            // stable sort, highest significance first
            for (int i = 1; i < nd; i++) begin
                key = dens[i];
                j = i;
                while (j > 0 && dens[j-1].sig < key.sig) begin
                    dens[j] = dens[j-1];
                    j--;
                end
                dens[j] = key;
            end
        end
        book_n = '{0, 0};
        book_sum = '{0, 0};
        if (nd == 0) begin
            expected_densities.push_back('{found: 1'b0, side: 1'b0, price: '0, qty: '0,
                                           quote: '0, dist_bp: '0, sig: '0, last: 1'b1});
        end else begin
            for (int i = 0; i < nd; i++) begin
                dens[i].last = (i == nd - 1);
                expected_densities.push_back(dens[i]);
            end
        end
    endtask

    // entered and left at a falling edge
    task automatic send_level(logic [31:0] mid, logic side, logic [31:0] price,
                              logic [31:0] qty, logic last);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {qty, price, mid};
        s_tuser  <= side;
        s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_level(mid, side, price, qty, last);
        levels_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCAN_DEPTH: depth_reg = value[5:0];
            CFG_THRESHOLD:  mult_reg = value[15:0];
            CFG_MIN_QUOTE:  minq_reg = value;
            default: ;
        endcase
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_densities.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic test_defaults;
        send_level(32'd1000, 1'b0, 32'd999, 32'd10, 1'b0);
        send_level(32'd1000, 1'b0, 32'd998, 32'd200, 1'b0);
        send_level(32'd1000, 1'b1, 32'd1001, 32'd5, 1'b1);
        drain();
    endtask

    task automatic test_extremes;
        write_reg(CFG_THRESHOLD, 64'd0);
        send_level(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_level(32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 1'b0);
        send_level(32'd1, 1'b1, 32'hFFFF_FFFF, 32'd1, 1'b1);
        drain();
        write_reg(CFG_MIN_QUOTE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_level(32'd7, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_level(32'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drain();
        write_reg(CFG_MIN_QUOTE, 64'd0);
        write_reg(CFG_THRESHOLD, 64'd65535);
        send_level(32'd50, 1'b0, 32'd40, 32'd9, 1'b0);
        send_level(32'd50, 1'b1, 32'd60, 32'd9, 1'b1);
        drain();
    endtask

    task automatic test_no_data;
        write_reg(CFG_THRESHOLD, 64'd0);
        // mid zero
        send_level(32'd0, 1'b0, 32'd10, 32'd10, 1'b0);
        send_level(32'd0, 1'b1, 32'd11, 32'd10, 1'b1);
        // empty ask side
        send_level(32'd10, 1'b0, 32'd9, 32'd4, 1'b1);
        // bid side sums to zero
        send_level(32'd10, 1'b0, 32'd9, 32'd0, 1'b0);
        send_level(32'd10, 1'b1, 32'd11, 32'd3, 1'b1);
        drain();
    endtask

    task automatic test_depth;
        write_reg(CFG_SCAN_DEPTH, 64'd0);
        send_level(32'd10, 1'b0, 32'd9, 32'd4, 1'b0);
        send_level(32'd10, 1'b1, 32'd11, 32'd4, 1'b1);
        drain();
        write_reg(CFG_SCAN_DEPTH, 64'd1);
        // second bid is past the depth and ignored
        send_level(32'd10, 1'b0, 32'd9, 32'd4, 1'b0);
        send_level(32'd10, 1'b0, 32'd8, 32'd900, 1'b0);
        send_level(32'd10, 1'b1, 32'd11, 32'd4, 1'b1);
        drain();
        // index past the register list, must be ignored
        write_reg(t_cfg_idx'(2'd3), 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_store_full;
        write_reg(CFG_SCAN_DEPTH, 64'd63);
        for (int i = 0; i < 17; i++)
            send_level(32'd5000, 1'b0, 32'd4990 - i, 32'd1 + (i % 3), 1'b0);
        send_level(32'd5000, 1'b1, 32'd5010, 32'd50, 1'b1);
        drain();
    endtask

    task automatic send_random_book;
        int nb, na, n;
        logic [31:0] mid, price, qty;
        logic side, ordered;
        nb = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        na = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        if (nb + na == 0) na = 1;
        n = nb + na;
        ordered = ($urandom_range(4) != 0);
        case ($urandom_range(9))
            0:       mid = 32'd0;
            1:       mid = $urandom();
            default: mid = $urandom_range(20000, 100);
        endcase
        for (int i = 0; i < n; i++) begin
            side = ordered ? (i >= nb) : $urandom_range(1);
            case ($urandom_range(7))
                0:       price = $urandom();
                default: price = mid + $urandom_range(200) - 100;
            endcase
            case ($urandom_range(7))
                0:       qty = $urandom();
                1:       qty = $urandom_range(5000);
                2:       qty = 32'd0;
                default: qty = $urandom_range(60);
            endcase
            send_level(mid, side, price, qty, i == n - 1);
        end
    endtask

    task automatic test_random;
        int target;
        int idle_mix [4][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{28, 28}};
        logic [63:0] mults [5] = '{0, 256, 768, 65535, 384};
        target = 0;
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            snd_idle = idle_mix[phase % 4][0];
            rcv_stall = idle_mix[phase % 4][1];
            case (phase)
                0:       write_reg(CFG_SCAN_DEPTH, 64'd1);
                3:       write_reg(CFG_SCAN_DEPTH, 64'd32);
                5:       write_reg(CFG_SCAN_DEPTH, 64'd63);
                default: write_reg(CFG_SCAN_DEPTH, $urandom_range(32, 2));
            endcase
            write_reg(CFG_THRESHOLD, (phase < 5) ? mults[phase] : $urandom_range(65535));
            case (phase % 3)
                0:       write_reg(CFG_MIN_QUOTE, 64'd0);
                1:       write_reg(CFG_MIN_QUOTE, $urandom_range(400000));
                default: write_reg(CFG_MIN_QUOTE, {$urandom(), $urandom()});
            endcase
            target += 49;
            while (levels_sent < target + 40) send_random_book();
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        rcv_stall = 0;
        test_defaults();
        test_extremes();
        test_no_data();
        test_depth();
        test_store_full();
        test_random();
        drain();
        repeat (100) @(negedge i_clk);
        if (fails == 0)
            $display("PASS order_book_density_detector_core");
        else
            $display("FAIL order_book_density_detector_core");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/obdd_pkg.sv
rtl/core/obdd_div.sv
rtl/core/obdd_dp.sv
rtl/core/obdd_ctrl.sv
rtl/core/order_book_density_detector_core.sv
test/order_book_density_detector_core_tb.sv
